>>> rtl/pbc_pkg.sv
// Package for the pattern BERT checker: transaction types, register indexes,
// reset values and the digital-milliwatt pattern constants.
// No dependencies; every module of the block imports it.
package pbc_pkg;

    localparam int PATTERN_LEN = 8;
    localparam int HIST_W      = 8 * (PATTERN_LEN - 1);

    // The first seven pattern octets as they sit in the history register,
    // oldest octet in the top byte, and the octet that completes the pattern.
    localparam logic [HIST_W-1:0] MW_HISTORY = 56'h1E0B0B1E9E8B8B;
    localparam logic [7:0]        MW_LAST    = 8'h9E;

    localparam logic [9:0]  FERR_MAX = 10'h3FF;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR_PERCENT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGUP_ENABLE     = 4'd3;

    localparam logic [9:0]  FRAME_LENGTH_RST      = 10'd160;
    localparam logic [15:0] WINDOW_LENGTH_RST     = 16'd8000;
    localparam logic [6:0]  MAX_ERROR_PERCENT_RST = 7'd10;

    localparam logic [6:0] PERCENT_SCALE = 7'd100;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
        logic       cng;
    } in_item_t;

    typedef struct packed {
        logic        frame_accepted;
        logic [9:0]  frame_errors;
        logic        in_sync;
        logic        lost_sync_event;
        logic        gained_sync_event;
        logic        window_done;
        logic [15:0] window_errors;
        logic [15:0] sync_loss_total;
        logic [15:0] noise_frame_total;
        logic [15:0] max_window_errors;
        logic        hangup_request;
    } result_t;

    typedef struct packed {
        logic [9:0]  frame_length;
        logic [15:0] window_length;
        logic [6:0]  max_error_percent;
        logic        hangup_enable;
    } cfg_t;

    // Summary of a frame that ends with the current transaction.
    typedef struct packed {
        logic       done;
        logic       accepted;
        logic       cng;
        logic [9:0] errors;
    } frame_end_t;

    // Expected octet at a given phase of the pattern.
    function automatic logic [7:0] mw_octet(input logic [2:0] phase);
        logic [7:0] oct;
        unique case (phase)
            3'd0:    oct = 8'h1E;
            3'd1:    oct = 8'h0B;
            3'd2:    oct = 8'h0B;
            3'd3:    oct = 8'h1E;
            3'd4:    oct = 8'h9E;
            3'd5:    oct = 8'h8B;
            3'd6:    oct = 8'h8B;
            default: oct = 8'h9E;
        endcase
        return oct;
    endfunction

endpackage

>>> rtl/pbc_frame.sv
// Per-frame pattern search and error counting for the pattern BERT checker.
// Depends on pbc_pkg for the transaction types and pattern constants.
module pbc_frame #(
    parameter int FRAME_MAX = 512
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pbc_pkg::in_item_t   item,
    input  logic [9:0]          frame_length,
    output pbc_pkg::frame_end_t fe
);
    import pbc_pkg::*;

    localparam int IDX_W = $clog2(FRAME_MAX + 2);
    localparam int W     = (IDX_W > 10) ? IDX_W : 10;
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(FRAME_MAX + 1);
    localparam logic [IDX_W-1:0] PREFIX_OF = IDX_W'(PATTERN_LEN - 1);

    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              match_reg, match_next;
    logic [2:0]        phase_reg, phase_next;
    logic [9:0]        fec_reg, fec_next;

    logic             hit, miss, len_ok;
    logic [IDX_W-1:0] prefix;
    logic [W:0]       prefix_sum;
    logic [9:0]       fec_hit, idx_clip, raw_errors;

    always_comb begin
        hit = !match_reg && (idx_reg >= PREFIX_OF) && (item.sample == MW_LAST)
              && (hist_reg == MW_HISTORY);
        miss = match_reg && (item.sample != mw_octet(phase_reg));

        // The octets in front of the pattern count as errors.
        prefix     = idx_reg - PREFIX_OF;
        prefix_sum = (W+1)'(prefix) + (W+1)'(fec_reg);
        fec_hit    = (prefix_sum > (W+1)'(FERR_MAX)) ? FERR_MAX : prefix_sum[9:0];

        if (hit) begin
            fec_next = fec_hit;
        end else if (miss && fec_reg != FERR_MAX) begin
            fec_next = fec_reg + 10'd1;
        end else begin
            fec_next = fec_reg;
        end

        match_next = match_reg | hit;
        if (hit) begin
            phase_next = 3'd0;
        end else if (match_reg) begin
            phase_next = phase_reg + 3'd1;
        end else begin
            phase_next = phase_reg;
        end
        hist_next = {hist_reg[HIST_W-9:0], item.sample};
        idx_next  = (idx_reg < IDX_MAX) ? idx_reg + IDX_W'(1) : idx_reg;

        len_ok   = (frame_length != 10'd0) && (32'(frame_length) <= 32'(FRAME_MAX));
        idx_clip = (W'(idx_next) > W'(FERR_MAX)) ? FERR_MAX : 10'(idx_next);
        raw_errors = match_next ? fec_next : idx_clip;

        fe.done = item.last;
        fe.cng  = item.cng;
        if (item.cng) begin
            // Idle octets never match, so the whole frame is in error.
            fe.accepted = len_ok;
            fe.errors   = len_ok ? frame_length : 10'd0;
        end else begin
            fe.accepted = len_ok && (W'(idx_next) == W'(frame_length));
            fe.errors   = fe.accepted ? raw_errors : 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            idx_reg   <= '0;
            match_reg <= 1'b0;
            phase_reg <= 3'd0;
            fec_reg   <= 10'd0;
        end else if (advance) begin
            if (item.last) begin
                hist_reg  <= '0;
                idx_reg   <= '0;
                match_reg <= 1'b0;
                phase_reg <= 3'd0;
                fec_reg   <= 10'd0;
            end else if (!item.cng) begin
                hist_reg  <= hist_next;
                idx_reg   <= idx_next;
                match_reg <= match_next;
                phase_reg <= phase_next;
                fec_reg   <= fec_next;
            end
        end
    end

endmodule

>>> rtl/pbc_window.sv
// Window accumulation, sync evaluation and status counters of the pattern
// BERT checker. Depends on pbc_pkg for the frame summary and result types.
module pbc_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pbc_pkg::frame_end_t fe,
    input  pbc_pkg::cfg_t       cfg,
    output pbc_pkg::result_t    res
);
    import pbc_pkg::*;

    logic [15:0] wec_reg, wec_next;
    logic [15:0] pc_reg, pc_next;
    logic        sync_reg, sync_next;
    logic [15:0] lost_reg, lost_next;
    logic [15:0] noise_reg, noise_next;
    logic [15:0] worst_reg, worst_next;

    logic        eval, exceed, lost, gained;
    logic [22:0] lhs, rhs;
    logic [15:0] noise_a, base_w, base_p;
    logic [16:0] sum_w, sum_p;

    always_comb begin
        noise_a = (fe.done && fe.cng && noise_reg != CNT_MAX) ? noise_reg + 16'd1
                                                              : noise_reg;
        eval = fe.done && fe.accepted && (cfg.window_length != 16'd0)
               && (pc_reg == cfg.window_length);
        lhs    = 23'(wec_reg) * 23'(PERCENT_SCALE);
        rhs    = 23'(cfg.max_error_percent) * 23'(pc_reg);
        exceed = lhs > rhs;
        lost   = eval && exceed && sync_reg;
        gained = eval && !exceed && !sync_reg;

        sync_next  = lost ? 1'b0 : (gained ? 1'b1 : sync_reg);
        lost_next  = (lost && lost_reg != CNT_MAX) ? lost_reg + 16'd1 : lost_reg;
        noise_next = gained ? 16'd0 : noise_a;
        worst_next = (eval && wec_reg > worst_reg) ? wec_reg : worst_reg;

        // A finished window restarts from zero before this frame is added.
        base_w = eval ? 16'd0 : wec_reg;
        base_p = eval ? 16'd0 : pc_reg;
        sum_w  = 17'(base_w) + 17'(fe.errors);
        sum_p  = 17'(base_p) + 17'(cfg.frame_length);
        if (fe.accepted) begin
            wec_next = sum_w[16] ? CNT_MAX : sum_w[15:0];
            pc_next  = sum_p[16] ? CNT_MAX : sum_p[15:0];
        end else begin
            wec_next = wec_reg;
            pc_next  = pc_reg;
        end

        res.frame_accepted    = fe.accepted;
        res.frame_errors      = fe.errors;
        res.in_sync           = sync_next;
        res.lost_sync_event   = lost;
        res.gained_sync_event = gained;
        res.window_done       = eval;
        res.window_errors     = eval ? wec_reg : 16'd0;
        res.sync_loss_total   = lost_next;
        res.noise_frame_total = noise_next;
        res.max_window_errors = worst_next;
        res.hangup_request    = lost && cfg.hangup_enable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wec_reg   <= 16'd0;
            pc_reg    <= 16'd0;
            sync_reg  <= 1'b0;
            lost_reg  <= 16'd0;
            noise_reg <= 16'd0;
            worst_reg <= 16'd0;
        end else if (advance && fe.done) begin
            wec_reg   <= wec_next;
            pc_reg    <= pc_next;
            sync_reg  <= sync_next;
            lost_reg  <= lost_next;
            noise_reg <= noise_next;
            worst_reg <= worst_next;
        end
    end

endmodule

>>> rtl/pattern_bert_checker_unit.sv
// Top level of the pattern BERT checker: input register, result register and
// configuration registers around pbc_frame and pbc_window. Depends on pbc_pkg.
//
//  Channel   Ports                                   Direction  Content
//  -------   -------------------------------------   ---------  ------------------------
//  input     s_valid, s_ready, s_item                in         one received octet
//  result    m_valid, m_ready, m_result              out        one status per frame end
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in      register write
//
// The block accepts one octet transaction every clock cycle unless the input is
// held off as described below. A transaction sits in the input register while
// the frame and window logic work on it; the result of a frame-ending octet is
// loaded into the result register, raising m_valid, when that octet leaves the
// input register. The frame state registers update on each octet that is
// neither cng nor frame-ending. When the result register is full and not being
// drained, a frame-ending octet waits in the input register and holds off the
// input; octets that do not end a frame never wait for the result side. Reset
// is synchronous and active low, loads the register defaults and clears all
// frame, window and status state. Configuration writes are always taken.
module pattern_bert_checker_unit #(
    parameter int FRAME_MAX = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pbc_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pbc_pkg::result_t                m_result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pbc_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Input register, holding the transaction that is being worked on.
    in_item_t in_reg;
    logic     in_valid_reg;

    // Result register.
    result_t out_reg;
    logic    out_valid_reg;

    frame_end_t fe;
    result_t    res;
    logic       out_free;
    logic       advance;

    // A frame-ending octet needs room in the result register; every other
    // octet at most updates the frame state and can always move on.
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && (out_free || !in_reg.last);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length      <= FRAME_LENGTH_RST;
            cfg_reg.window_length     <= WINDOW_LENGTH_RST;
            cfg_reg.max_error_percent <= MAX_ERROR_PERCENT_RST;
            cfg_reg.hangup_enable     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_LENGTH:      cfg_reg.frame_length      <= cfg_data[9:0];
                CFG_WINDOW_LENGTH:     cfg_reg.window_length     <= cfg_data[15:0];
                CFG_MAX_ERROR_PERCENT: cfg_reg.max_error_percent <= cfg_data[6:0];
                CFG_HANGUP_ENABLE:     cfg_reg.hangup_enable     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && fe.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fe.done) begin
            out_reg <= res;
        end
    end

    pbc_frame #(
        .FRAME_MAX (FRAME_MAX)
    ) u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item         (in_reg),
        .frame_length (cfg_reg.frame_length),
        .fe           (fe)
    );

    pbc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .fe      (fe),
        .cfg     (cfg_reg),
        .res     (res)
    );

endmodule
